@@ rtl/cbs_pkg.sv @@
// package: shared depth and leaf sideband types for the bezier subdivider
`timescale 1ns / 1ps
`default_nettype none
package cbs_pkg;
  localparam int DEPTH_BITS = 3;
  localparam int NUM_PTS = 4;
  localparam int NUM_AXES = 3;
  localparam int SEGS_PER_LEAF = 3;

  typedef logic [DEPTH_BITS-1:0] depth_t;

  // sideband that travels with a leaf through the split stages
  typedef struct packed {
    logic       valid;
    logic [1:0] seg_idx;
    logic       last_leaf;
  } leaf_ctl_t;
endpackage
`default_nettype wire

@@ rtl/cbs_split_stage.sv @@
// one de casteljau level: registered midpoint split keeping left or right half, or pass-through when not splitting
`timescale 1ns / 1ps
`default_nettype none
module cbs_split_stage #(
  parameter int COORD_BITS = 16
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                advance,
  input  wire                                in_valid,
  input  wire                                do_split,
  input  wire                                keep_right,
  input  wire logic signed [COORD_BITS-1:0]  in_pts [4][3],
  output logic                               out_valid,
  output logic signed [COORD_BITS-1:0]       out_pts [4][3]
);
  import cbs_pkg::*;

  logic signed [COORD_BITS-1:0] res [4][3];

  function automatic logic signed [COORD_BITS-1:0] avg2(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    logic signed [COORD_BITS:0] s;
    s = {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
    return s[COORD_BITS:1];
  endfunction

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      logic signed [COORD_BITS-1:0] a0, a1, a2, b0, b1, md;
      a0 = avg2(in_pts[0][k], in_pts[1][k]);
      a1 = avg2(in_pts[1][k], in_pts[2][k]);
      a2 = avg2(in_pts[2][k], in_pts[3][k]);
      b0 = avg2(a0, a1);
      b1 = avg2(a1, a2);
      md = avg2(b0, b1);
      if (!do_split) begin
        for (int p = 0; p < NUM_PTS; p++) res[p][k] = in_pts[p][k];
      end else if (keep_right) begin
        res[0][k] = md; res[1][k] = b1; res[2][k] = a2; res[3][k] = in_pts[3][k];
      end else begin
        res[0][k] = in_pts[0][k]; res[1][k] = a0; res[2][k] = b0; res[3][k] = md;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_pts <= res;
    end
  end
endmodule
`default_nettype wire

@@ rtl/cbs_leaf_seq.sv @@
// input holding register and leaf/segment sequencer
`timescale 1ns / 1ps
`default_nettype none
module cbs_leaf_seq #(
  parameter int COORD_BITS = 16,
  parameter int MAX_DEPTH  = 4
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire logic signed [COORD_BITS-1:0]  in_pts [4][3],
  input  wire cbs_pkg::depth_t               depth,
  input  wire                                advance,
  output cbs_pkg::leaf_ctl_t                 ctl,
  output logic [MAX_DEPTH-1:0]               path,
  output logic signed [COORD_BITS-1:0]       root [4][3]
);
  import cbs_pkg::*;

  logic                 busy;
  logic [MAX_DEPTH-1:0] leaf;
  logic [1:0]           seg;
  logic [MAX_DEPTH-1:0] leaf_max;
  logic [MAX_DEPTH-1:0] path_src;
  logic [$clog2(MAX_DEPTH+1)-1:0] eff_depth;

  always_comb begin
    if (depth > DEPTH_BITS'(MAX_DEPTH)) eff_depth = ($clog2(MAX_DEPTH+1))'(MAX_DEPTH);
    else eff_depth = depth[$clog2(MAX_DEPTH+1)-1:0];
    leaf_max  = MAX_DEPTH'((MAX_DEPTH+1)'(1) << eff_depth) - MAX_DEPTH'(1);
  end

  // bits used by split level j are the top bits of leaf index, msb first
  assign path_src = leaf << (($clog2(MAX_DEPTH+1))'(MAX_DEPTH) - eff_depth);
  always_comb begin
    for (int j = 0; j < MAX_DEPTH; j++) begin
      path[j] = path_src[MAX_DEPTH-1-j];
    end
  end

  assign in_stall      = busy;
  assign ctl.valid     = busy;
  assign ctl.seg_idx   = seg;
  assign ctl.last_leaf = (leaf == leaf_max);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      leaf <= '0;
      seg  <= '0;
    end else if (!busy) begin
      if (in_valid) begin
        busy <= 1'b1;
        leaf <= '0;
        seg  <= '0;
      end
    end else if (advance) begin
      if (seg == 2'(SEGS_PER_LEAF - 1)) begin
        seg <= '0;
        if (leaf == leaf_max) busy <= 1'b0;
        else leaf <= leaf + MAX_DEPTH'(1);
      end else begin
        seg <= seg + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && in_valid) root <= in_pts;
  end
endmodule
`default_nettype wire

@@ rtl/cubic_bezier_subdivider_unit.sv @@
// Cubic Bezier subdivider, top level.
// Takes one curve (four 3D Q8.8 control points) on the input channel and
// emits 3*2^depth line segments on the output channel, leaf curves in
// left-first order, with last_segment set on the final one.
// The depth register is written through cfg_valid/cfg_ready/cfg_data; values
// above MAX_DEPTH saturate. Write it only while the block is idle.
// A curve is held in an input register while a sequencer walks its
// segments; each segment passes a chain of MAX_DEPTH registered split stages
// (one de Casteljau level each) and an output register.
// Throughput: one segment per cycle while the receiver does not stall; a
// curve holds the sequencer, with in_stall high, until its last segment is
// issued, and only then is the next curve accepted.
// Reset clears depth to 0 and all valid bits. When the receiver stalls, the
// whole split pipeline freezes; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none
module cubic_bezier_subdivider_unit #(
  parameter int MAX_DEPTH  = 4,
  parameter int COORD_BITS = 16
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire cbs_pkg::depth_t           cfg_data,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire logic signed [COORD_BITS-1:0] p0_x, p0_y, p0_z,
  input  wire logic signed [COORD_BITS-1:0] p1_x, p1_y, p1_z,
  input  wire logic signed [COORD_BITS-1:0] p2_x, p2_y, p2_z,
  input  wire logic signed [COORD_BITS-1:0] p3_x, p3_y, p3_z,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic signed [COORD_BITS-1:0]   seg_start_x, seg_start_y, seg_start_z,
  output logic signed [COORD_BITS-1:0]   seg_end_x, seg_end_y, seg_end_z,
  output logic                           last_segment
);
  import cbs_pkg::*;

  depth_t depth;
  logic   advance;
  logic signed [COORD_BITS-1:0] in_pts [4][3];
  logic signed [COORD_BITS-1:0] root [4][3];
  logic signed [COORD_BITS-1:0] pts [MAX_DEPTH+1][4][3];
  logic [MAX_DEPTH:0] vld;
  logic [MAX_DEPTH-1:0] path;
  leaf_ctl_t ctl;
  // sideband and path bits delayed alongside the split stages
  leaf_ctl_t ctl_d [MAX_DEPTH+1];
  logic [MAX_DEPTH-1:0] path_d [MAX_DEPTH+1];

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) depth <= '0;
    else if (cfg_valid) depth <= cfg_data;
  end

  assign in_pts[0] = '{p0_x, p0_y, p0_z};
  assign in_pts[1] = '{p1_x, p1_y, p1_z};
  assign in_pts[2] = '{p2_x, p2_y, p2_z};
  assign in_pts[3] = '{p3_x, p3_y, p3_z};

  // pipeline moves whenever the output register is free or being taken
  assign advance = !out_valid || !out_stall;

  cbs_leaf_seq #(.COORD_BITS(COORD_BITS), .MAX_DEPTH(MAX_DEPTH)) u_seq (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_pts(in_pts), .depth(depth), .advance(advance),
    .ctl(ctl), .path(path), .root(root)
  );

  assign pts[0]    = root;
  assign vld[0]    = ctl.valid;
  assign ctl_d[0]  = ctl;
  assign path_d[0] = path;

  logic [MAX_DEPTH-1:0] used;
  always_comb begin
    for (int j = 0; j < MAX_DEPTH; j++) begin
      used[j] = (32'(j) < 32'((depth > DEPTH_BITS'(MAX_DEPTH)) ? DEPTH_BITS'(MAX_DEPTH) : depth));
    end
  end

  for (genvar j = 0; j < MAX_DEPTH; j++) begin : g_split
    cbs_split_stage #(.COORD_BITS(COORD_BITS)) u_split (
      .clk(clk), .rst(rst), .advance(advance), .in_valid(vld[j]),
      .do_split(used[j]), .keep_right(path_d[j][j]),
      .in_pts(pts[j]), .out_valid(vld[j+1]), .out_pts(pts[j+1])
    );
    always_ff @(posedge clk) begin
      if (advance) begin
        ctl_d[j+1]  <= ctl_d[j];
        path_d[j+1] <= path_d[j];
      end
    end
  end

  logic [1:0] sg;
  logic signed [COORD_BITS-1:0] sa [3];
  logic signed [COORD_BITS-1:0] ea [3];
  always_comb begin
    sg = ctl_d[MAX_DEPTH].seg_idx;
    for (int k = 0; k < NUM_AXES; k++) begin
      case (sg)
        2'd0: begin sa[k] = pts[MAX_DEPTH][0][k]; ea[k] = pts[MAX_DEPTH][1][k]; end
        2'd1: begin sa[k] = pts[MAX_DEPTH][1][k]; ea[k] = pts[MAX_DEPTH][2][k]; end
        default: begin sa[k] = pts[MAX_DEPTH][2][k]; ea[k] = pts[MAX_DEPTH][3][k]; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (advance) out_valid <= vld[MAX_DEPTH];
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      seg_start_x  <= sa[0]; seg_start_y <= sa[1]; seg_start_z <= sa[2];
      seg_end_x    <= ea[0]; seg_end_y   <= ea[1]; seg_end_z   <= ea[2];
      last_segment <= ctl_d[MAX_DEPTH].last_leaf &&
                      (sg == 2'(SEGS_PER_LEAF - 1));
    end
  end
endmodule
`default_nettype wire

@@ dv/cubic_bezier_subdivider_unit_test.sv @@
// testbench: bezier subdivider checked against a de casteljau predictor
`timescale 1ns / 1ps
module cubic_bezier_subdivider_unit_test;
  import cbs_pkg::*;

  localparam int MAX_DEPTH = 4;
  localparam int CB = 16;
  localparam int N_RANDOM = 220;

  typedef logic signed [CB-1:0] coord_t;
  typedef coord_t curve_t [4][3];

  typedef struct packed {
    coord_t sx, sy, sz, ex, ey, ez;
    logic last;
  } segment_t;

  // directed rows: curve, depth to apply first, and a known first segment
  typedef struct {
    coord_t pts [12];
    int depth;
    bit has_known;
    segment_t known;
  } curve_row_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  depth_t cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  coord_t pin [12];
  logic out_valid;
  logic out_stall = 0;
  coord_t seg_start_x, seg_start_y, seg_start_z, seg_end_x, seg_end_y, seg_end_z;
  logic last_segment;

  segment_t segments_due [$];
  depth_t depth_reg = '0;
  int mismatches = 0;
  bit hold_long = 0;

  always #1 clk = ~clk;

  initial foreach (pin[i]) pin[i] = '0;

  cubic_bezier_subdivider_unit #(.MAX_DEPTH(MAX_DEPTH), .COORD_BITS(CB)) i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .p0_x(pin[0]), .p0_y(pin[1]), .p0_z(pin[2]),
    .p1_x(pin[3]), .p1_y(pin[4]), .p1_z(pin[5]),
    .p2_x(pin[6]), .p2_y(pin[7]), .p2_z(pin[8]),
    .p3_x(pin[9]), .p3_y(pin[10]), .p3_z(pin[11]),
    .out_valid(out_valid), .out_stall(out_stall),
    .seg_start_x(seg_start_x), .seg_start_y(seg_start_y), .seg_start_z(seg_start_z),
    .seg_end_x(seg_end_x), .seg_end_y(seg_end_y), .seg_end_z(seg_end_z),
    .last_segment(last_segment)
  );

  function automatic coord_t half_sum(coord_t a, coord_t b);
    logic signed [CB:0] s;
    s = a + b;
    return coord_t'(s >>> 1);
  endfunction

  // queue every segment of one curve at the current depth
  function automatic void predict_segments(coord_t pts [12]);
    curve_t root, leaf;
    coord_t a0, a1, a2, b0, b1, m;
    int d, nleaf;
    segment_t s;
    d = (depth_reg > MAX_DEPTH) ? MAX_DEPTH : int'(depth_reg);
    nleaf = 1 << d;
    for (int p = 0; p < 4; p++)
      for (int k = 0; k < 3; k++) root[p][k] = pts[p*3+k];
    for (int i = 0; i < nleaf; i++) begin
      leaf = root;
      for (int l = 0; l < d; l++) begin
        for (int k = 0; k < 3; k++) begin
          a0 = half_sum(leaf[0][k], leaf[1][k]);
          a1 = half_sum(leaf[1][k], leaf[2][k]);
          a2 = half_sum(leaf[2][k], leaf[3][k]);
          b0 = half_sum(a0, a1);
          b1 = half_sum(a1, a2);
          m = half_sum(b0, b1);
          if ((i >> (d - 1 - l)) & 1) begin
            leaf[0][k] = m; leaf[1][k] = b1; leaf[2][k] = a2;
          end else begin
            leaf[1][k] = a0; leaf[2][k] = b0; leaf[3][k] = m;
          end
        end
      end
      for (int p = 0; p < 3; p++) begin
        s = '{leaf[p][0], leaf[p][1], leaf[p][2],
              leaf[p+1][0], leaf[p+1][1], leaf[p+1][2],
              (i == nleaf - 1) && (p == 2)};
        segments_due.push_back(s);
      end
    end
  endfunction

  task automatic write_depth(int d);
    @(negedge clk);
    cfg_data <= depth_t'(d);
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    depth_reg = depth_t'(d);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic wait_idle();
    while (segments_due.size() != 0) @(posedge clk);
    repeat (MAX_DEPTH + 8) @(posedge clk);
  endtask

  task automatic send_curve(coord_t pts [12]);
    repeat ($urandom_range(0, 13)) @(negedge clk);
    @(negedge clk);
    foreach (pts[i]) pin[i] <= pts[i];
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    predict_segments(pts);
    @(negedge clk);
    in_valid <= 0;
  endtask

  function automatic coord_t rnd_coord();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return coord_t'($urandom_range(0, 3) - 2);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // receiver: random stall per word, one long hold-off on request
  initial begin
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_stall <= 1;
        repeat (300) @(negedge clk);
        hold_long = 0;
        out_stall <= 0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_stall <= 0;
      end
    end
  end

  always @(posedge clk) begin
    segment_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{seg_start_x, seg_start_y, seg_start_z,
              seg_end_x, seg_end_y, seg_end_z, last_segment};
      if (segments_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
      end else begin
        want = segments_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %h actual %h", want, got);
        end
      end
    end
  end

  initial begin
    curve_row_t rows [$];
    curve_row_t r;
    coord_t pts [12];
    rows = {};
    // zero curve after reset at depth 0: all zeros, one endpoint flag later
    foreach (r.pts[i]) r.pts[i] = '0;
    r.depth = 0; r.has_known = 1; r.known = '0; rows.push_back(r);
    foreach (r.pts[i]) r.pts[i] = 16'sh7fff;
    r.depth = 4; r.has_known = 1; r.known = {{6{16'sh7fff}}, 1'b0}; rows.push_back(r);
    foreach (r.pts[i]) r.pts[i] = 16'sh8000;
    r.depth = 1; r.has_known = 1; r.known = {{6{16'sh8000}}, 1'b0}; rows.push_back(r);
    // alternating extremes, odd sums to exercise floor rounding
    foreach (r.pts[i]) r.pts[i] = (i % 2) ? 16'sh7fff : 16'sh8000;
    r.depth = 2; r.has_known = 0; rows.push_back(r);
    foreach (r.pts[i]) r.pts[i] = (i % 3) ? -16'sd1 : 16'sd1;
    r.depth = 3; r.has_known = 0; rows.push_back(r);
    // depths above maximum saturate
    for (int d = 5; d <= 7; d++) begin
      foreach (r.pts[i]) r.pts[i] = coord_t'(i * 1000 - 5000);
      r.depth = d; r.has_known = 0; rows.push_back(r);
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    foreach (rows[n]) begin
      if (n > 0 || rows[n].depth != 0) begin
        wait_idle();
        write_depth(rows[n].depth);
      end
      if (rows[n].has_known) segments_due.push_back(rows[n].known);
      send_curve(rows[n].pts);
      // the typed row matches the first predicted segment; keep one copy
      if (rows[n].has_known) begin
        if (segments_due[segments_due.size() - (3 << ((depth_reg > 4) ? 4 : depth_reg))]
            !== rows[n].known) begin
          mismatches++;
          $display("predictor disagrees with directed row %0d", n);
        end
        void'(segments_due.pop_front());
      end
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 40 == 0) begin
        wait_idle();
        write_depth((n == 0) ? 0 : (n == 80) ? 4 : $urandom_range(0, 7));
      end
      if (n == 100) hold_long = 1;
      foreach (pts[i]) pts[i] = rnd_coord();
      if (n == 100) begin
        // back to back while the receiver holds off
        @(negedge clk);
        foreach (pts[i]) pin[i] <= pts[i];
        in_valid <= 1;
        do @(posedge clk); while (in_stall);
        predict_segments(pts);
        for (int j = 0; j < 6; j++) begin
          foreach (pts[i]) pts[i] = rnd_coord();
          @(negedge clk);
          foreach (pts[i]) pin[i] <= pts[i];
          do @(posedge clk); while (in_stall);
          predict_segments(pts);
        end
        @(negedge clk);
        in_valid <= 0;
      end else send_curve(pts);
    end
    wait_idle();
    if (mismatches == 0 && segments_due.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
